// ----- rtl/cts_pkg.sv -----
// Package for the call-timing shadow stack: payload types, codes and constants.
`timescale 1ns / 1ps

package cts_pkg;

    // Default stack depth
    localparam int STACK_DEPTH_DEF = 128;

    // Field widths
    localparam int ADDR_W  = 64;
    localparam int TIME_W  = 27;
    localparam int DEPTH_W = 7;
    localparam int MAXD_W  = 8;

    // Timestamp wraps every 100 s of microseconds
    localparam logic [TIME_W-1:0] WRAP_US = TIME_W'(100 * 1000000);

    // Configuration reset values
    localparam logic [TIME_W-1:0] MIN_COST_RST  = TIME_W'(1000);
    localparam logic [MAXD_W-1:0] MAX_DEPTH_RST = MAXD_W'(3);

    // Configuration register indexes
    localparam logic [1:0] CFG_RECORD_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MAIN_THREAD   = 2'd1;
    localparam logic [1:0] CFG_MIN_COST      = 2'd2;
    localparam logic [1:0] CFG_MAX_DEPTH     = 2'd3;

    // Command actions
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Input command
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] class_ref;
        logic [ADDR_W-1:0] selector_ref;
        logic [ADDR_W-1:0] return_addr;
        logic [TIME_W-1:0] now_us;
    } t_cmd;

    // Result record
    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  return_addr_out;
        logic               log_valid;
        logic [ADDR_W-1:0]  log_class;
        logic [ADDR_W-1:0]  log_selector;
        logic [DEPTH_W-1:0] log_depth;
        logic [TIME_W-1:0]  log_cost;
    } t_result;

    // One stack entry as held in the entry RAM
    typedef struct packed {
        logic [ADDR_W-1:0] class_ref;
        logic [ADDR_W-1:0] selector_ref;
        logic [ADDR_W-1:0] return_addr;
    } t_entry;

    // Live configuration handed to the pop evaluation
    typedef struct packed {
        logic              timing;
        logic [TIME_W-1:0] min_cost;
        logic [MAXD_W-1:0] max_depth;
    } t_cfg;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

endpackage

// ----- rtl/cts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cts_eval.sv -----
// Pop evaluation: elapsed time with wrap, log decision and result assembly.
`timescale 1ns / 1ps

module cts_eval #(
    parameter int AW = 7
) (
    input  cts_pkg::t_entry              i_entry,
    input  logic [cts_pkg::TIME_W-1:0]   i_start_us,
    input  logic [cts_pkg::TIME_W-1:0]   i_now_us,
    input  logic [AW-1:0]                i_level,
    input  cts_pkg::t_cfg                i_cfg,
    output cts_pkg::t_result             o_result
);
    import cts_pkg::*;

    // Common compare width for level against max_depth + 1
    localparam int XW = (AW > MAXD_W + 1) ? AW : MAXD_W + 1;

    logic [TIME_W:0] now_adj;
    logic [TIME_W:0] cost;
    logic [XW-1:0]   level_x;
    logic [XW-1:0]   limit_x;
    logic            do_log;

    // Add the wrap when the clock has wrapped since the push
    always_comb begin
        now_adj = {1'b0, i_now_us};
        if (i_now_us < i_start_us) begin
            now_adj = {1'b0, i_now_us} + {1'b0, WRAP_US};
        end
        cost = now_adj - {1'b0, i_start_us};
    end

    // Log when timing is on, cost exceeds the floor and the call is shallow enough
    always_comb begin
        level_x = XW'(i_level);
        limit_x = XW'(i_cfg.max_depth) + XW'(1);
        do_log  = i_cfg.timing && (cost > {1'b0, i_cfg.min_cost}) && (level_x < limit_x);
    end

    // Result record
    always_comb begin
        o_result                 = '0;
        o_result.status          = ST_OK;
        o_result.return_addr_out = i_entry.return_addr;
        if (do_log) begin
            o_result.log_valid    = 1'b1;
            o_result.log_class    = i_entry.class_ref;
            o_result.log_selector = i_entry.selector_ref;
            o_result.log_depth    = DEPTH_W'(level_x);
            o_result.log_cost     = cost[TIME_W-1:0];
        end
    end

endmodule

// ----- rtl/call_timing_shadow_stack.sv -----
// Top level of the call-timing shadow stack.
//
// Usage:
//   A command (push or pop with class, selector, return address and the
//   current microsecond time) is transferred when start is high and busy is
//   low. Every command gives exactly one result on o_result, marked by o_done
//   for a single cycle; the receiver cannot stall it.
//   A push writes the entry RAM at the accept edge; its result follows in the
//   next cycle and busy stays low, so pushes are taken every cycle.
//   A pop reads the top entry from the registered-read entry and time RAMs;
//   busy is high in S_READ and the result appears in the cycle after, so
//   no command is taken until the pop is through. A push on a full stack or
//   a pop on an empty stack completes like a push, with the status code set.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle. Reset empties the stack and loads the default
//   configuration; RAM contents are not cleared.
`timescale 1ns / 1ps

module call_timing_shadow_stack #(
    parameter int STACK_DEPTH = cts_pkg::STACK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cts_pkg::t_cmd                i_cmd,
    output logic                         o_done,
    output cts_pkg::t_result             o_result,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [cts_pkg::TIME_W-1:0]   i_cfg_data
);
    import cts_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    // Configuration registers
    logic              r_record_enable;
    logic              r_main_thread;
    logic [TIME_W-1:0] r_min_cost;
    logic [MAXD_W-1:0] r_max_depth;

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_done, n_done;
    t_result         r_result, n_result;
    logic [AW-1:0]   r_level, n_level;
    logic [TIME_W-1:0] r_now, n_now;

    logic      accept;
    logic      full;
    logic      empty;
    logic      timing;
    logic      ent_we;
    logic      time_we;
    logic      rd_en;
    t_entry    wr_entry;
    t_entry    rd_entry;
    logic [TIME_W-1:0] rd_start;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    t_cfg      cfg;
    t_result   pop_result;

    assign busy   = (r_state == S_READ);
    assign accept = start && !busy;
    assign full   = (r_count == CW'(STACK_DEPTH));
    assign empty  = (r_count == '0);
    assign timing = r_record_enable && r_main_thread;

    assign cfg.timing    = timing;
    assign cfg.min_cost  = r_min_cost;
    assign cfg.max_depth = r_max_depth;

    // RAM addressing: push writes at the count, pop reads the top entry
    assign wr_addr  = AW'(r_count);
    assign rd_addr  = AW'(r_count - CW'(1));
    assign wr_entry = '{class_ref:    i_cmd.class_ref,
                        selector_ref: i_cmd.selector_ref,
                        return_addr:  i_cmd.return_addr};
    assign ent_we   = accept && (i_cmd.action == ACT_PUSH) && !full;
    assign time_we  = ent_we && timing;
    assign rd_en    = accept && (i_cmd.action == ACT_POP) && !empty;

    // Entry RAM: class, selector and return address
    cts_ram #(
        .WIDTH(EW),
        .DEPTH(STACK_DEPTH)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (ent_we),
        .i_waddr(wr_addr),
        .i_wdata(wr_entry),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_entry)
    );

    // Start-time RAM, written only when timing is on
    cts_ram #(
        .WIDTH(TIME_W),
        .DEPTH(STACK_DEPTH)
    ) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (time_we),
        .i_waddr(wr_addr),
        .i_wdata(i_cmd.now_us),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_start)
    );

    // Cost and log evaluation on the read data
    cts_eval #(
        .AW(AW)
    ) u_eval (
        .i_entry   (rd_entry),
        .i_start_us(rd_start),
        .i_now_us  (r_now),
        .i_level   (r_level),
        .i_cfg     (cfg),
        .o_result  (pop_result)
    );

    // Command sequencing
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = 1'b0;
        n_result = r_result;
        n_level  = r_level;
        n_now    = r_now;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result = '0;
                    if (i_cmd.action == ACT_PUSH) begin
                        n_done = 1'b1;
                        if (full) begin
                            n_result.status = ST_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (empty) begin
                        n_done          = 1'b1;
                        n_result.status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_level = rd_addr;
                        n_now   = i_cmd.now_us;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_result = pop_result;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_level  <= n_level;
        r_now    <= n_now;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_enable <= 1'b1;
            r_main_thread   <= 1'b1;
            r_min_cost      <= MIN_COST_RST;
            r_max_depth     <= MAX_DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RECORD_ENABLE: r_record_enable <= i_cfg_data[0];
                CFG_MAIN_THREAD:   r_main_thread   <= i_cfg_data[0];
                CFG_MIN_COST:      r_min_cost      <= i_cfg_data;
                CFG_MAX_DEPTH:     r_max_depth     <= i_cfg_data[MAXD_W-1:0];
                default:           r_max_depth     <= r_max_depth;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
